// ===== rtl/hnm_pkg.sv =====
// Shared types, constants and codes of the height-to-normal-map block.
`default_nettype none
package hnm_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int SCALE_W     = 8;
   localparam int FWIDTH_W    = 11;
   localparam int FHEIGHT_W   = 13;
   localparam int OUT_COL_W   = 10;
   localparam int OUT_ROW_W   = 12;

   localparam logic [CSR_INDEX_W-1:0] REG_NORMAL_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

   localparam logic [SCALE_W-1:0]   SCALE_RESET   = 8'd255;
   localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 11'd1024;
   localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 13'd1024;

   // floor(s / 3) == (s * 683) >> 11 for s in 0..765
   localparam logic [9:0] THIRD_RECIP = 10'd683;
   localparam logic [7:0] ENC_MID     = 8'd127;
   localparam logic [6:0] ENC_GAIN    = 7'd127;

   typedef struct packed {
      logic signed [8:0] dx;
      logic signed [8:0] dy;
      logic signed [8:0] dz;
   } hnm_vec_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] z;
   } hnm_norm_type;

   typedef enum logic [6:0] {
      M_IDLE = 7'b0000001,
      M_SUM  = 7'b0000010,
      M_INIT = 7'b0000100,
      M_ROOT = 7'b0001000,
      M_NUM  = 7'b0010000,
      M_DIV  = 7'b0100000,
      M_DONE = 7'b1000000
   } hnm_mstate_type;

   typedef enum logic [4:0] {
      C_IDLE  = 5'b00001,
      C_READ  = 5'b00010,
      C_START = 5'b00100,
      C_WAIT  = 5'b01000,
      C_PUSH  = 5'b10000
   } hnm_cstate_type;

endpackage
`default_nettype wire

// ===== rtl/hnm_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module hnm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/hnm_normal_unit.sv =====
// Iterative vector normalizer: sum of squares, bit-serial root, radix-2 divides.
`default_nettype none
module hnm_normal_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire hnm_pkg::hnm_vec_type vec,
   output logic                      done,
   output hnm_pkg::hnm_norm_type     norm
);
   import hnm_pkg::*;

   hnm_mstate_type    state_ff, state_in;
   hnm_vec_type       vec_ff, vec_in;
   logic [18:0]       sum_ff, sum_in;
   logic [33:0]       rad_ff, rad_in;
   logic [19:0]       rem_ff, rem_in;
   logic [16:0]       root_ff, root_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [24:0]       dv_ff, dv_in;
   logic [24:0]       num_ff [3];
   logic [24:0]       num_in [3];
   logic [7:0]        quo_ff [3];
   logic [7:0]        quo_in [3];

   logic signed [8:0]  lane_d [3];
   logic signed [17:0] sq_x, sq_y, sq_z;
   logic [19:0]        rem_n, trial;
   logic signed [18:0] t;

   assign lane_d[0] = vec_ff.dx;
   assign lane_d[1] = vec_ff.dy;
   assign lane_d[2] = vec_ff.dz;

   assign sq_x  = vec_ff.dx * vec_ff.dx;
   assign sq_y  = vec_ff.dy * vec_ff.dy;
   assign sq_z  = vec_ff.dz * vec_ff.dz;
   assign rem_n = {rem_ff[17:0], rad_ff[33:32]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      vec_in   = vec_ff;
      sum_in   = sum_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      dv_in    = dv_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      t        = '0;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               vec_in   = vec;
               state_in = M_SUM;
            end
         end
         M_SUM: begin
            sum_in   = 19'(18'(sq_x) + 18'(sq_y)) + 19'(18'(sq_z));
            state_in = M_INIT;
         end
         M_INIT: begin
            if (sum_ff == '0) begin
               for (int i = 0; i < 3; i++) begin
                  quo_in[i] = ENC_MID;
               end
               state_in = M_DONE;
            end else begin
               rad_in   = {sum_ff[17:0], 16'b0};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = 5'd16;
               state_in = M_ROOT;
            end
         end
         M_ROOT: begin
            rad_in = {rad_ff[31:0], 2'b00};
            if (rem_n >= trial) begin
               rem_in  = rem_n - trial;
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = rem_n;
               root_in = {root_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = M_NUM;
            end
         end
         M_NUM: begin
            for (int i = 0; i < 3; i++) begin
               t = 19'({{2{lane_d[i][8]}}, lane_d[i], 8'b0}) + $signed({2'b00, root_ff});
               if (t[18]) begin
                  num_in[i] = '0;
               end else begin
                  num_in[i] = 25'(t[17:0]) * 25'(ENC_GAIN);
               end
               quo_in[i] = '0;
            end
            dv_in    = {1'b0, root_ff, 7'b0};
            cnt_in   = 5'd7;
            state_in = M_DIV;
         end
         M_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (num_ff[i] >= dv_ff) begin
                  num_in[i] = num_ff[i] - dv_ff;
                  quo_in[i] = {quo_ff[i][6:0], 1'b1};
               end else begin
                  quo_in[i] = {quo_ff[i][6:0], 1'b0};
               end
            end
            dv_in  = {1'b0, dv_ff[24:1]};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = M_DONE;
            end
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      vec_ff  <= vec_in;
      sum_ff  <= sum_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      dv_ff   <= dv_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
   end

   assign done   = (state_ff == M_DONE);
   assign norm.x = quo_ff[0];
   assign norm.y = quo_ff[1];
   assign norm.z = quo_ff[2];
endmodule
`default_nettype wire

// ===== rtl/height_to_normal_map.sv =====
// Top level: grey conversion, line buffer control, sequencing and output stage.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_ready      req_red, req_green, req_blue
//   rsp      out        rsp_valid / rsp_ready      rsp_normal_x/y/z, rsp_out_column,
//                                                  rsp_out_row, rsp_last_of_run
//   csr      in         csr_wr_en                  csr_index, csr_wdata
//
// An item yields 0, 1 or 2 results, each computed in turn by the shared normal unit:
// 17 root steps and 8 divide steps per result, none for a zero vector.
// The line buffer is one RAM with a registered read; no clearing pass.
// Reset is synchronous; the block accepts an item in the first cycle after it.
// A result waits in the output register while the next item is accepted.
`default_nettype none
module height_to_normal_map #(
   parameter int MAX_WIDTH  = hnm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = hnm_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_red,
   input  wire logic [7:0]                       req_green,
   input  wire logic [7:0]                       req_blue,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_normal_x,
   output logic [7:0]                            rsp_normal_y,
   output logic [7:0]                            rsp_normal_z,
   output logic [hnm_pkg::OUT_COL_W-1:0]         rsp_out_column,
   output logic [hnm_pkg::OUT_ROW_W-1:0]         rsp_out_row,
   output logic                                  rsp_last_of_run,
   input  wire logic                             csr_wr_en,
   input  wire logic [hnm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hnm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hnm_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WBW = $clog2(MAX_WIDTH + 1);
   localparam int HBW = $clog2(MAX_HEIGHT + 1);

   hnm_cstate_type       state_ff, state_in;
   logic [SCALE_W-1:0]   scale_ff;
   logic [FWIDTH_W-1:0]  fwidth_ff;
   logic [FHEIGHT_W-1:0] fheight_ff;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [7:0]           up_left_ff, up_left_in;
   logic [7:0]           cur_left_ff, cur_left_in;
   logic [7:0]           grey_ff, grey_in;
   logic [CW-1:0]        xi_ff, xi_in;
   logic [RW-1:0]        yi_ff, yi_in;
   logic                 last_row_ff, last_row_in;
   logic                 pend_b_ff, pend_b_in;
   logic                 use_b_ff, use_b_in;
   hnm_vec_type          vec_a_ff, vec_a_in;
   hnm_vec_type          vec_b_ff, vec_b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   hnm_norm_type         rsp_norm_ff, rsp_norm_in;
   logic [OUT_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [WBW-1:0] w_eff;
   logic [HBW-1:0] h_eff;
   logic [9:0]     rgb_sum;
   logic [19:0]    rgb_prod;
   logic [7:0]     grey;
   logic [CW-1:0]  x_idx;
   logic [7:0]     rd_grey;
   logic [7:0]     left_a, left_b;
   logic           mem_wr;
   logic           accept;
   logic           out_free;
   logic           math_start, math_done;
   hnm_vec_type    math_vec;
   hnm_norm_type   math_norm;

   always_comb begin
      if (fwidth_ff == '0) begin
         w_eff = WBW'(1);
      end else if (32'(fwidth_ff) > MAX_WIDTH) begin
         w_eff = WBW'(MAX_WIDTH);
      end else begin
         w_eff = WBW'(fwidth_ff);
      end
      if (fheight_ff == '0) begin
         h_eff = HBW'(1);
      end else if (32'(fheight_ff) > MAX_HEIGHT) begin
         h_eff = HBW'(MAX_HEIGHT);
      end else begin
         h_eff = HBW'(fheight_ff);
      end
   end

   assign rgb_sum  = 10'(req_red) + 10'(req_green) + 10'(req_blue);
   assign rgb_prod = 20'(rgb_sum) * 20'(THIRD_RECIP);
   assign grey     = rgb_prod[18:11];
   assign x_idx    = (32'(col_ff) >= MAX_WIDTH) ? '0 : col_ff;

   assign req_ready = (state_ff == C_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_wr    = (state_ff == C_READ);

   hnm_ram #(
      .WIDTH(8),
      .DEPTH(MAX_WIDTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(xi_ff),
      .wr_data(grey_ff),
      .rd_addr(x_idx),
      .rd_data(rd_grey)
   );

   assign left_a = (xi_ff == '0) ? rd_grey : up_left_ff;
   assign left_b = (xi_ff == '0) ? grey_ff : cur_left_ff;

   assign math_start = (state_ff == C_START);
   assign math_vec   = use_b_ff ? vec_b_ff : vec_a_ff;

   hnm_normal_unit u_norm (
      .clock(clock),
      .reset(reset),
      .start(math_start),
      .vec  (math_vec),
      .done (math_done),
      .norm (math_norm)
   );

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      up_left_in   = up_left_ff;
      cur_left_in  = cur_left_ff;
      grey_in      = grey_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      last_row_in  = last_row_ff;
      pend_b_in    = pend_b_ff;
      use_b_in     = use_b_ff;
      vec_a_in     = vec_a_ff;
      vec_b_in     = vec_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_norm_in  = rsp_norm_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         C_IDLE: begin
            if (accept) begin
               grey_in     = grey;
               xi_in       = x_idx;
               yi_in       = row_ff;
               last_row_in = (32'(row_ff) + 1 >= 32'(h_eff));
               state_in    = C_READ;
            end
         end
         C_READ: begin
            vec_a_in.dx = $signed({1'b0, left_a}) - $signed({1'b0, rd_grey});
            vec_a_in.dy = $signed({1'b0, grey_ff}) - $signed({1'b0, rd_grey});
            vec_a_in.dz = $signed({1'b0, scale_ff});
            vec_b_in.dx = $signed({1'b0, left_b}) - $signed({1'b0, grey_ff});
            vec_b_in.dy = '0;
            vec_b_in.dz = $signed({1'b0, scale_ff});
            up_left_in  = rd_grey;
            cur_left_in = grey_ff;
            pend_b_in   = last_row_ff;
            if (32'(xi_ff) + 1 >= 32'(w_eff)) begin
               col_in = '0;
               if (32'(yi_ff) + 1 >= 32'(h_eff)) begin
                  row_in = '0;
               end else begin
                  row_in = yi_ff + RW'(1);
               end
            end else begin
               col_in = xi_ff + CW'(1);
            end
            if (yi_ff != '0) begin
               use_b_in = 1'b0;
               state_in = C_START;
            end else if (last_row_ff) begin
               use_b_in = 1'b1;
               state_in = C_START;
            end else begin
               state_in = C_IDLE;
            end
         end
         C_START: begin
            state_in = C_WAIT;
         end
         C_WAIT: begin
            if (math_done) begin
               state_in = C_PUSH;
            end
         end
         C_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_norm_in  = math_norm;
               rsp_col_in   = OUT_COL_W'(xi_ff);
               if (use_b_ff) begin
                  rsp_row_in  = OUT_ROW_W'(yi_ff);
                  rsp_last_in = 1'b1;
                  pend_b_in   = 1'b0;
                  state_in    = C_IDLE;
               end else begin
                  rsp_row_in  = OUT_ROW_W'(yi_ff - RW'(1));
                  rsp_last_in = !last_row_ff;
                  if (pend_b_ff) begin
                     use_b_in = 1'b1;
                     state_in = C_START;
                  end else begin
                     state_in = C_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         scale_ff     <= SCALE_RESET;
         fwidth_ff    <= FWIDTH_RESET;
         fheight_ff   <= FHEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         up_left_ff   <= '0;
         cur_left_ff  <= '0;
         pend_b_ff    <= 1'b0;
         use_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         up_left_ff   <= up_left_in;
         cur_left_ff  <= cur_left_in;
         pend_b_ff    <= pend_b_in;
         use_b_ff     <= use_b_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_NORMAL_SCALE: scale_ff   <= csr_wdata[SCALE_W-1:0];
               REG_FRAME_WIDTH:  fwidth_ff  <= csr_wdata[FWIDTH_W-1:0];
               REG_FRAME_HEIGHT: fheight_ff <= csr_wdata[FHEIGHT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      grey_ff     <= grey_in;
      xi_ff       <= xi_in;
      yi_ff       <= yi_in;
      last_row_ff <= last_row_in;
      vec_a_ff    <= vec_a_in;
      vec_b_ff    <= vec_b_in;
      rsp_norm_ff <= rsp_norm_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_normal_x    = rsp_norm_ff.x;
   assign rsp_normal_y    = rsp_norm_ff.y;
   assign rsp_normal_z    = rsp_norm_ff.z;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_last_of_run = rsp_last_ff;
endmodule
`default_nettype wire

// ===== rtl/hnm_checker.sv =====
// Port-level checker for the height-to-normal-map block, bound to the top level.
`default_nettype none
module hnm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_normal_x,
   input wire logic [7:0]  rsp_normal_y,
   input wire logic [7:0]  rsp_normal_z,
   input wire logic [9:0]  rsp_out_column,
   input wire logic [11:0] rsp_out_row,
   input wire logic        rsp_last_of_run
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_out_column)
         && $stable(rsp_out_row) && $stable(rsp_last_of_run))
      else $error("result item changed while stalled");

   a_enc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x != 8'd255 && rsp_normal_y != 8'd255
         && rsp_normal_z != 8'd255)
      else $error("normal component out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");
endmodule

bind height_to_normal_map hnm_checker u_hnm_checker (.*);
`default_nettype wire

// ===== bench/height_to_normal_map_test.sv =====
// Self-checking bench for height_to_normal_map: random frames, random stalls on both sides.
`default_nettype none
module height_to_normal_map_test;
   import hnm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 100;
   localparam int ITEM_GOAL = 950;

   typedef struct {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
   } pixel_type;

   typedef struct {
      bit [7:0] nx;
      bit [7:0] ny;
      bit [7:0] nz;
      bit [OUT_COL_W-1:0] column;
      bit [OUT_ROW_W-1:0] row;
      bit last;
   } normal_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic rsp_valid;
   logic rsp_ready;
   logic [7:0] rsp_normal_x;
   logic [7:0] rsp_normal_y;
   logic [7:0] rsp_normal_z;
   logic [OUT_COL_W-1:0] rsp_out_column;
   logic [OUT_ROW_W-1:0] rsp_out_row;
   logic rsp_last_of_run;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   height_to_normal_map dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_out_column(rsp_out_column),
      .rsp_out_row(rsp_out_row), .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pixel_type pending_pixels[$];
   normal_type expected_normals[$];

   bit [7:0] scale_reg;
   bit [FWIDTH_W-1:0] width_reg;
   bit [FHEIGHT_W-1:0] height_reg;
   bit [7:0] grey_row[0:MAX_WIDTH_DEF-1];
   bit [7:0] upper_left;
   bit [7:0] current_left;
   int column_pos;
   int row_pos;

   int errors;
   int pixels_in;
   int normals_out;
   int frames;
   int quiet_cycles;
   int queued;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want, normals_out);
   endtask

   function automatic longint square_root(input longint value);
      longint remainder;
      longint root;
      longint probe;
      remainder = value;
      root = 0;
      probe = 64'sd1 <<< 60;
      while (probe > remainder) probe = probe >>> 2;
      while (probe != 0) begin
         if (remainder >= root + probe) begin
            remainder = remainder - root - probe;
            root = (root >>> 1) + probe;
         end else begin
            root = root >>> 1;
         end
         probe = probe >>> 2;
      end
      return root;
   endfunction

   function automatic bit [7:0] encode_axis(input int diff, input longint length);
      longint num;
      num = 127 * (longint'(diff) * 256 + length);
      if (num < 0) num = 0;
      return 8'(num / length);
   endfunction

   function automatic void push_normal(input int dx, input int dy, input int col,
                                       input int row, input bit last);
      normal_type n;
      longint sum;
      longint length;
      sum = longint'(dx * dx + dy * dy) + longint'(scale_reg) * scale_reg;
      if (sum == 0) begin
         n.nx = ENC_MID;
         n.ny = ENC_MID;
         n.nz = ENC_MID;
      end else begin
         length = square_root(sum <<< 16);
         n.nx = encode_axis(dx, length);
         n.ny = encode_axis(dy, length);
         n.nz = encode_axis(int'(scale_reg), length);
      end
      n.column = OUT_COL_W'(col);
      n.row = OUT_ROW_W'(row);
      n.last = last;
      expected_normals.push_back(n);
   endfunction

   function automatic void predict_normals(input pixel_type p);
      int w;
      int h;
      int grey;
      int centre;
      int left;
      bit last_row;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg);
      if (column_pos >= MAX_WIDTH_DEF) column_pos = 0;
      grey = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
      last_row = (row_pos + 1 >= h);
      centre = grey_row[column_pos];
      if (row_pos >= 1) begin
         left = (column_pos == 0) ? centre : upper_left;
         push_normal(left - centre, grey - centre, column_pos, row_pos - 1, !last_row);
      end
      if (last_row) begin
         left = (column_pos == 0) ? grey : current_left;
         push_normal(left - grey, 0, column_pos, row_pos, 1'b1);
      end
      upper_left = centre;
      grey_row[column_pos] = grey;
      current_left = grey;
      column_pos++;
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   // driver
   pixel_type drive_pixel;
   int drive_gap;
   bit drive_burst;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drive_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_normals(drive_pixel);
            pixels_in++;
         end
         if ((req_valid && req_ready) || !req_valid) begin
            if (drive_gap > 0 || pending_pixels.size() == 0) begin
               if (drive_gap > 0) drive_gap--;
               req_valid <= 1'b0;
            end else begin
               drive_pixel = pending_pixels.pop_front();
               req_valid <= 1'b1;
               req_red <= drive_pixel.red;
               req_green <= drive_pixel.green;
               req_blue <= drive_pixel.blue;
               if ($urandom_range(0, 40) == 0) drive_burst = !drive_burst;
               drive_gap = drive_burst ? 0 : $urandom_range(0, 10);
            end
         end
      end
   end

   // monitor
   normal_type oldest;
   int stall;
   bit stall_burst;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_normals.size() == 0) begin
               report("unexpected item", 1, 0);
            end else begin
               oldest = expected_normals.pop_front();
               if (rsp_normal_x !== oldest.nx) report("normal_x", rsp_normal_x, oldest.nx);
               if (rsp_normal_y !== oldest.ny) report("normal_y", rsp_normal_y, oldest.ny);
               if (rsp_normal_z !== oldest.nz) report("normal_z", rsp_normal_z, oldest.nz);
               if (rsp_out_column !== oldest.column)
                  report("out_column", rsp_out_column, oldest.column);
               if (rsp_out_row !== oldest.row) report("out_row", rsp_out_row, oldest.row);
               if (rsp_last_of_run !== oldest.last)
                  report("last_of_run", rsp_last_of_run, oldest.last);
            end
            normals_out++;
            if ($urandom_range(0, 40) == 0) stall_burst = !stall_burst;
            stall = stall_burst ? 0 : $urandom_range(0, 10);
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d items outstanding", expected_normals.size());
         $display("height_to_normal_map regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic settle();
      while (pending_pixels.size() != 0 || req_valid || expected_normals.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         REG_NORMAL_SCALE: scale_reg = 8'(value);
         REG_FRAME_WIDTH:  width_reg = FWIDTH_W'(value);
         REG_FRAME_HEIGHT: height_reg = FHEIGHT_W'(value);
         default: ;
      endcase
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      int shade;
      case ($urandom_range(0, 9))
         0: p = '{8'd0, 8'd0, 8'd0};
         1: p = '{8'd255, 8'd255, 8'd255};
         2: begin
            shade = $urandom_range(0, 255);
            p = '{8'(shade), 8'(shade), 8'(shade)};
         end
         default: p = '{8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      return p;
   endfunction

   // run one complete frame; width and height as written, before clamping
   task automatic run_frame(input int scale, input int w, input int h, input bit corners);
      int w_eff;
      int h_eff;
      int k;
      pixel_type corner_set[6];
      settle();
      write_reg(REG_NORMAL_SCALE, scale);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      corner_set = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
                     '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd2, 8'd0, 8'd0}};
      w_eff = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
      h_eff = (h == 0) ? 1 : ((h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h);
      for (k = 0; k < w_eff * h_eff; k++)
         pending_pixels.push_back(corners ? corner_set[k % 6] : random_pixel());
      queued += w_eff * h_eff;
      frames++;
   endtask

   initial begin
      int w;
      int h;
      int scale;
      reset = 1'b1;
      req_valid = 1'b0;
      req_red = 8'd0;
      req_green = 8'd0;
      req_blue = 8'd0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      pixels_in = 0;
      normals_out = 0;
      frames = 0;
      queued = 0;
      scale_reg = SCALE_RESET;
      width_reg = FWIDTH_RESET;
      height_reg = FHEIGHT_RESET;
      column_pos = 0;
      row_pos = 0;
      upper_left = 0;
      current_left = 0;
      foreach (grey_row[i]) grey_row[i] = 0;
      drive_burst = 0;
      stall_burst = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_SPARE, 13'h1fff);
      run_frame(255, 3, 3, 1);
      run_frame(0, 1, 1, 1);
      run_frame(0, 2, 2, 1);
      run_frame(1, 0, 0, 1);
      run_frame(128, 4, 1, 1);
      run_frame(255, 2047, 1, 0);
      run_frame(200, 1, 40, 0);
      while (queued < ITEM_GOAL + 150) begin
         case ($urandom_range(0, 3))
            0: scale = 0;
            1: scale = 255;
            default: scale = $urandom_range(0, 255);
         endcase
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         run_frame(scale, w, h, 0);
      end
      settle();

      $display("%0d frames, %0d pixels in, %0d normals checked", frames, pixels_in,
               normals_out);
      $display("widths 1..1024, heights 1..40, scales 0..255, random stalls both sides");
      if (errors == 0) begin
         $display("height_to_normal_map regression: pass");
      end else begin
         $display("height_to_normal_map regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
